>>> src/mvna_pkg.sv
// Shared constants, types and helpers of the mesh vertex normal accumulator.
package mvna_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int SUM_WIDTH    = 24;
  localparam int ADDR_W       = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int INDEX_W      = 10;
  localparam int COORD_W      = 16;
  localparam int UNIT_W       = 16;
  // Working vector width: holds an exact cross product and any sum.
  localparam int VEC_W        = 36;
  localparam int POS_W        = 3 * COORD_W;
  localparam int SUMS_W       = 3 * SUM_WIDTH;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_TRI  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  // Vertex or component selector.
  localparam logic [1:0] SEL_A = 2'd0;
  localparam logic [1:0] SEL_B = 2'd1;
  localparam logic [1:0] SEL_C = 2'd2;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_LATCH,
    PH_CLEAR,
    PH_LOAD,
    PH_POS,
    PH_CROSS,
    PH_RDSUM,
    PH_CAPSUM,
    PH_MAG,
    PH_PRE,
    PH_SQ,
    PH_SQRT,
    PH_DIV,
    PH_UPD,
    PH_OUT,
    PH_OUTZ
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic [4:0] step;
    logic [1:0] sel;
  } cmd_t;

  typedef struct packed {
    logic a_ok;
    logic tri_ok;
    logic m_zero;
    logic m_big;
    logic clr_last;
  } stat_t;

  function automatic logic [ADDR_W-1:0] to_addr(input logic [INDEX_W-1:0] idx);
    return ADDR_W'(idx);
  endfunction

  function automatic logic in_range(input logic [INDEX_W-1:0] idx);
    return (32'(idx) < 32'(MAX_VERTICES));
  endfunction

endpackage

>>> src/mvna_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mvna_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/mvna_ctrl.sv
// Controller state machine that sequences the normal accumulator datapath.
module mvna_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [1:0]          opcode,
  input  mvna_pkg::stat_t     stat,
  output mvna_pkg::cmd_t      cmd,
  output logic                busy
);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DECODE = 4'd2;
  localparam logic [3:0] S_LOAD   = 4'd3;
  localparam logic [3:0] S_POS    = 4'd4;
  localparam logic [3:0] S_CROSS  = 4'd5;
  localparam logic [3:0] S_RDSUM  = 4'd6;
  localparam logic [3:0] S_CAPSUM = 4'd7;
  localparam logic [3:0] S_MAG    = 4'd8;
  localparam logic [3:0] S_PRE    = 4'd9;
  localparam logic [3:0] S_SQ     = 4'd10;
  localparam logic [3:0] S_SQRT   = 4'd11;
  localparam logic [3:0] S_DIV    = 4'd12;
  localparam logic [3:0] S_UPD    = 4'd13;
  localparam logic [3:0] S_OUT    = 4'd14;
  localparam logic [3:0] S_OUTZ   = 4'd15;

  logic [3:0] state, state_next;
  logic [4:0] step, step_next;
  logic [1:0] sel, sel_next;
  logic [1:0] op, op_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      step  <= '0;
      sel   <= mvna_pkg::SEL_A;
      op    <= mvna_pkg::OP_LOAD;
    end else begin
      state <= state_next;
      step  <= step_next;
      sel   <= sel_next;
      op    <= op_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    step_next  = step;
    sel_next   = sel;
    op_next    = op;
    cmd.phase  = mvna_pkg::PH_IDLE;
    cmd.step   = step;
    cmd.sel    = sel;
    unique case (state)
      S_CLEAR: begin
        cmd.phase = mvna_pkg::PH_CLEAR;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.phase  = mvna_pkg::PH_LATCH;
          op_next    = opcode;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        step_next = '0;
        sel_next  = mvna_pkg::SEL_A;
        priority if (op == mvna_pkg::OP_LOAD) begin
          state_next = S_LOAD;
        end else if (op == mvna_pkg::OP_TRI) begin
          state_next = stat.tri_ok ? S_POS : S_IDLE;
        end else if (op == mvna_pkg::OP_READ) begin
          state_next = stat.a_ok ? S_RDSUM : S_OUTZ;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_LOAD: begin
        cmd.phase  = mvna_pkg::PH_LOAD;
        state_next = S_IDLE;
      end
      S_POS: begin
        cmd.phase = mvna_pkg::PH_POS;
        if (step == 5'd3) begin
          step_next  = '0;
          state_next = S_CROSS;
        end else begin
          step_next = step + 5'd1;
        end
      end
      S_CROSS: begin
        cmd.phase = mvna_pkg::PH_CROSS;
        if (step == 5'd6) begin
          step_next  = '0;
          state_next = S_MAG;
        end else begin
          step_next = step + 5'd1;
        end
      end
      S_RDSUM: begin
        cmd.phase  = mvna_pkg::PH_RDSUM;
        state_next = S_CAPSUM;
      end
      S_CAPSUM: begin
        cmd.phase  = mvna_pkg::PH_CAPSUM;
        state_next = S_MAG;
      end
      S_MAG: begin
        cmd.phase  = mvna_pkg::PH_MAG;
        state_next = S_PRE;
      end
      S_PRE: begin
        cmd.phase = mvna_pkg::PH_PRE;
        step_next = '0;
        priority if (stat.m_zero) begin
          state_next = (op == mvna_pkg::OP_READ) ? S_OUTZ : S_IDLE;
        end else if (!stat.m_big) begin
          state_next = S_SQ;
        end
      end
      S_SQ: begin
        cmd.phase = mvna_pkg::PH_SQ;
        if (step == 5'd3) begin
          step_next  = '0;
          state_next = S_SQRT;
        end else begin
          step_next = step + 5'd1;
        end
      end
      S_SQRT: begin
        cmd.phase = mvna_pkg::PH_SQRT;
        step_next = step + 5'd1;
        if (step == 5'd31) begin
          sel_next   = mvna_pkg::SEL_A;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.phase = mvna_pkg::PH_DIV;
        if (step == 5'd15) begin
          step_next = '0;
          if (sel == mvna_pkg::SEL_C) begin
            sel_next   = mvna_pkg::SEL_A;
            state_next = (op == mvna_pkg::OP_READ) ? S_OUT : S_UPD;
          end else begin
            sel_next = sel + 2'd1;
          end
        end else begin
          step_next = step + 5'd1;
        end
      end
      S_UPD: begin
        cmd.phase = mvna_pkg::PH_UPD;
        if (step == 5'd1) begin
          step_next = '0;
          if (sel == mvna_pkg::SEL_C) begin
            state_next = S_IDLE;
          end else begin
            sel_next = sel + 2'd1;
          end
        end else begin
          step_next = 5'd1;
        end
      end
      S_OUT: begin
        cmd.phase  = mvna_pkg::PH_OUT;
        state_next = S_IDLE;
      end
      S_OUTZ: begin
        cmd.phase  = mvna_pkg::PH_OUTZ;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_latch_only_on_start: assert property (@(posedge clk) disable iff (rst)
    (cmd.phase == mvna_pkg::PH_LATCH) |-> start)
    else $error("item latched without start");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted item");

  a_clear_leads_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR && stat.clr_last) |=> !busy)
    else $error("clearing pass did not end in idle");

endmodule

>>> src/mvna_dp.sv
// Datapath of the normal accumulator: stores, multiplier, square root and divider.
module mvna_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  mvna_pkg::cmd_t         cmd,
  output mvna_pkg::stat_t        stat,
  input  logic [9:0]             index_a,
  input  logic [9:0]             index_b,
  input  logic [9:0]             index_c,
  input  logic signed [15:0]     coord_x,
  input  logic signed [15:0]     coord_y,
  input  logic signed [15:0]     coord_z,
  output logic                   done,
  output logic [9:0]             vertex_id,
  output logic signed [15:0]     unit_x,
  output logic signed [15:0]     unit_y,
  output logic signed [15:0]     unit_z,
  output logic                   zero_sum
);

  localparam int AW  = mvna_pkg::ADDR_W;
  localparam int SW  = mvna_pkg::SUM_WIDTH;
  localparam int VW  = mvna_pkg::VEC_W;

  // Latched item.
  logic [9:0]         ia, ib, ic;
  logic signed [15:0] cx, cy, cz;

  // Corner positions: [corner][component].
  logic signed [15:0] pos [3][3];
  logic signed [VW-1:0] vec [3];
  logic [VW-1:0]        mag [3];
  logic [2:0]           sgn;
  logic signed [63:0]   prod;
  logic [63:0]          sq_rem;
  logic [63:0]          root;
  logic [31:0]          rem;
  logic [14:0]          dlo;
  logic [14:0]          quo;
  logic signed [15:0]   unit [3];
  logic [AW-1:0]        clr_addr;

  // Memory ports.
  logic                       pos_we;
  logic [AW-1:0]              pos_raddr;
  logic [mvna_pkg::POS_W-1:0] pos_rdata;
  logic                       sum_we;
  logic [AW-1:0]              sum_waddr;
  logic [AW-1:0]              sum_raddr;
  logic [mvna_pkg::SUMS_W-1:0] sum_wdata;
  logic [mvna_pkg::SUMS_W-1:0] sum_rdata;

  logic [9:0]           sel_idx;
  logic [9:0]           pos_idx;
  logic signed [16:0]   e1 [3];
  logic signed [16:0]   e2 [3];
  logic signed [31:0]   mul_a, mul_b;
  logic signed [63:0]   mul_p;
  logic [63:0]          sq_bit;
  logic [63:0]          sq_try;
  logic [45:0]          num;
  logic [32:0]          rem2;
  logic                 qbit;
  logic [14:0]          quo_next;
  logic [1:0]           prev_step;

  mvna_ram #(.WIDTH(mvna_pkg::POS_W), .DEPTH(mvna_pkg::MAX_VERTICES)) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (mvna_pkg::to_addr(ia)),
    .wdata ({cz, cy, cx}),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  mvna_ram #(.WIDTH(mvna_pkg::SUMS_W), .DEPTH(mvna_pkg::MAX_VERTICES)) u_sum_ram (
    .clk   (clk),
    .we    (sum_we),
    .waddr (sum_waddr),
    .wdata (sum_wdata),
    .raddr (sum_raddr),
    .rdata (sum_rdata)
  );

  // Status toward the controller.
  assign stat.a_ok     = mvna_pkg::in_range(ia);
  assign stat.tri_ok   = mvna_pkg::in_range(ia) && mvna_pkg::in_range(ib) &&
                         mvna_pkg::in_range(ic);
  assign stat.m_zero   = (mag[0] == '0) && (mag[1] == '0) && (mag[2] == '0);
  assign stat.m_big    = (|mag[0][VW-1:31]) || (|mag[1][VW-1:31]) ||
                         (|mag[2][VW-1:31]);
  assign stat.clr_last = (clr_addr == AW'(mvna_pkg::MAX_VERTICES - 1));

  function automatic logic signed [SW-1:0] sat_add(input logic signed [SW-1:0] s,
                                                  input logic signed [15:0] d);
    logic signed [SW:0] t;
    t = SW'(0) + (SW+1)'(s) + (SW+1)'(d);
    if (t[SW] != t[SW-1]) begin
      return t[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end
    return t[SW-1:0];
  endfunction

  always_comb begin
    unique case (cmd.sel)
      mvna_pkg::SEL_A: sel_idx = ia;
      mvna_pkg::SEL_B: sel_idx = ib;
      default:         sel_idx = ic;
    endcase
    unique case (cmd.step[1:0])
      2'd0:    pos_idx = ia;
      2'd1:    pos_idx = ib;
      default: pos_idx = ic;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1[i] = 17'(pos[1][i]) - 17'(pos[0][i]);
      e2[i] = 17'(pos[2][i]) - 17'(pos[0][i]);
    end
  end

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.phase == mvna_pkg::PH_CROSS) begin
      unique case (cmd.step)
        5'd0:    begin mul_a = 32'(e1[1]); mul_b = 32'(e2[2]); end
        5'd1:    begin mul_a = 32'(e1[2]); mul_b = 32'(e2[1]); end
        5'd2:    begin mul_a = 32'(e1[2]); mul_b = 32'(e2[0]); end
        5'd3:    begin mul_a = 32'(e1[0]); mul_b = 32'(e2[2]); end
        5'd4:    begin mul_a = 32'(e1[0]); mul_b = 32'(e2[1]); end
        5'd5:    begin mul_a = 32'(e1[1]); mul_b = 32'(e2[0]); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else begin
      unique case (cmd.step[1:0])
        2'd0:    begin mul_a = {1'b0, mag[0][30:0]}; mul_b = {1'b0, mag[0][30:0]}; end
        2'd1:    begin mul_a = {1'b0, mag[1][30:0]}; mul_b = {1'b0, mag[1][30:0]}; end
        default: begin mul_a = {1'b0, mag[2][30:0]}; mul_b = {1'b0, mag[2][30:0]}; end
      endcase
    end
    mul_p = mul_a * mul_b;
  end

  // One bit of the square root and one bit of the division per cycle.
  always_comb begin
    sq_bit  = 64'd1 << (6'd62 - {cmd.step, 1'b0});
    sq_try  = root + sq_bit;
    unique case (cmd.sel)
      mvna_pkg::SEL_A: num = {mag[0][30:0], 14'd0} + 46'(root[31:1]);
      mvna_pkg::SEL_B: num = {mag[1][30:0], 14'd0} + 46'(root[31:1]);
      default:         num = {mag[2][30:0], 14'd0} + 46'(root[31:1]);
    endcase
    rem2     = {rem, dlo[14]};
    qbit     = (rem2 >= {1'b0, root[31:0]});
    quo_next = {quo[13:0], qbit};
    prev_step = cmd.step[1:0] - 2'd1;
  end

  // Memory control.
  always_comb begin
    pos_we    = (cmd.phase == mvna_pkg::PH_LOAD) && stat.a_ok;
    pos_raddr = mvna_pkg::to_addr(pos_idx);
    sum_we    = 1'b0;
    sum_waddr = mvna_pkg::to_addr(ia);
    sum_wdata = '0;
    sum_raddr = mvna_pkg::to_addr(ia);
    unique case (cmd.phase)
      mvna_pkg::PH_CLEAR: begin
        sum_we    = 1'b1;
        sum_waddr = clr_addr;
      end
      mvna_pkg::PH_LOAD: begin
        sum_we = stat.a_ok;
      end
      mvna_pkg::PH_UPD: begin
        sum_raddr = mvna_pkg::to_addr(sel_idx);
        sum_waddr = mvna_pkg::to_addr(sel_idx);
        sum_we    = (cmd.step == 5'd1);
        sum_wdata = {sat_add(sum_rdata[3*SW-1:2*SW], unit[2]),
                     sat_add(sum_rdata[2*SW-1:SW], unit[1]),
                     sat_add(sum_rdata[SW-1:0], unit[0])};
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      done <= (cmd.phase == mvna_pkg::PH_OUT) || (cmd.phase == mvna_pkg::PH_OUTZ);
      if (cmd.phase == mvna_pkg::PH_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    unique case (cmd.phase)
      mvna_pkg::PH_LATCH: begin
        ia <= index_a;
        ib <= index_b;
        ic <= index_c;
        cx <= coord_x;
        cy <= coord_y;
        cz <= coord_z;
      end
      mvna_pkg::PH_POS: begin
        if (cmd.step != 5'd0) begin
          pos[prev_step][0] <= pos_rdata[15:0];
          pos[prev_step][1] <= pos_rdata[31:16];
          pos[prev_step][2] <= pos_rdata[47:32];
        end
      end
      mvna_pkg::PH_CROSS: begin
        if (cmd.step != 5'd6) begin
          prod <= mul_p;
        end
        unique case (cmd.step)
          5'd1: vec[0] <= VW'(prod);
          5'd2: vec[0] <= vec[0] - VW'(prod);
          5'd3: vec[1] <= VW'(prod);
          5'd4: vec[1] <= vec[1] - VW'(prod);
          5'd5: vec[2] <= VW'(prod);
          5'd6: vec[2] <= vec[2] - VW'(prod);
          default: begin
          end
        endcase
      end
      mvna_pkg::PH_CAPSUM: begin
        vec[0] <= VW'($signed(sum_rdata[SW-1:0]));
        vec[1] <= VW'($signed(sum_rdata[2*SW-1:SW]));
        vec[2] <= VW'($signed(sum_rdata[3*SW-1:2*SW]));
      end
      mvna_pkg::PH_MAG: begin
        for (int i = 0; i < 3; i++) begin
          sgn[i] <= vec[i][VW-1];
          mag[i] <= vec[i][VW-1] ? VW'(-vec[i]) : VW'(vec[i]);
        end
      end
      mvna_pkg::PH_PRE: begin
        if (stat.m_big) begin
          for (int i = 0; i < 3; i++) begin
            mag[i] <= mag[i] >> 1;
          end
        end
      end
      mvna_pkg::PH_SQ: begin
        if (cmd.step != 5'd3) begin
          prod <= mul_p;
        end
        if (cmd.step == 5'd1) begin
          sq_rem <= 64'(prod);
        end else if (cmd.step != 5'd0) begin
          sq_rem <= sq_rem + 64'(prod);
        end
        root <= '0;
      end
      mvna_pkg::PH_SQRT: begin
        if (sq_rem >= sq_try) begin
          sq_rem <= sq_rem - sq_try;
          root   <= (root >> 1) + sq_bit;
        end else begin
          root <= root >> 1;
        end
      end
      mvna_pkg::PH_DIV: begin
        if (cmd.step == 5'd0) begin
          rem <= 32'(num[45:15]);
          dlo <= num[14:0];
          quo <= '0;
        end else begin
          dlo <= {dlo[13:0], 1'b0};
          quo <= quo_next;
          rem <= qbit ? 32'(rem2 - {1'b0, root[31:0]}) : rem2[31:0];
          if (cmd.step == 5'd15) begin
            unit[cmd.sel] <= sgn[cmd.sel] ? -$signed({1'b0, quo_next})
                                          : $signed({1'b0, quo_next});
          end
        end
      end
      mvna_pkg::PH_OUT: begin
        vertex_id <= ia;
        unit_x    <= unit[0];
        unit_y    <= unit[1];
        unit_z    <= unit[2];
        zero_sum  <= 1'b0;
      end
      mvna_pkg::PH_OUTZ: begin
        vertex_id <= ia;
        unit_x    <= '0;
        unit_y    <= '0;
        unit_z    <= '0;
        zero_sum  <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

  a_zero_means_zero: assert property (@(posedge clk) disable iff (rst)
    (done && zero_sum) |-> (unit_x == 16'sd0 && unit_y == 16'sd0 && unit_z == 16'sd0))
    else $error("zero sum with nonzero components");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    (done && !zero_sum) |-> (unit_x <= 16'sd16384 && unit_x >= -16'sd16384 &&
                             unit_y <= 16'sd16384 && unit_y >= -16'sd16384 &&
                             unit_z <= 16'sd16384 && unit_z >= -16'sd16384))
    else $error("component beyond unit length");

endmodule

>>> src/mesh_vertex_normal_accumulator.sv
// Top level of the mesh vertex normal accumulator: controller plus datapath.
// A nonzero vector is normalised by a 32-step square root and three 16-step divisions,
// one per component, run on a single divider; a large cross product first takes up to
// two prescale shifts. A zero sum or a degenerate triangle skips these steps.
// Throughput: one item at a time; busy stays high until the item is finished.
// Reset: rst is synchronous; a clearing pass over all MAX_VERTICES (1024) entries
// then zeroes every normal sum with busy high. Results show for one cycle with done.
module mesh_vertex_normal_accumulator (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         opcode,
  input  logic [9:0]         index_a,
  input  logic [9:0]         index_b,
  input  logic [9:0]         index_c,
  input  logic signed [15:0] coord_x,
  input  logic signed [15:0] coord_y,
  input  logic signed [15:0] coord_z,
  output logic               done,
  output logic [9:0]         vertex_id,
  output logic signed [15:0] unit_x,
  output logic signed [15:0] unit_y,
  output logic signed [15:0] unit_z,
  output logic               zero_sum
);

  // The controller steps the datapath through each item with one command a
  // cycle; the datapath reports range checks, the vector magnitude state and
  // the end of the clearing pass back as status.
  mvna_pkg::cmd_t  cmd;
  mvna_pkg::stat_t stat;

  mvna_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  // The datapath holds the position and sum memories and a single shared
  // multiplier used for both the cross product and the squared length.
  mvna_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .index_a   (index_a),
    .index_b   (index_b),
    .index_c   (index_c),
    .coord_x   (coord_x),
    .coord_y   (coord_y),
    .coord_z   (coord_z),
    .done      (done),
    .vertex_id (vertex_id),
    .unit_x    (unit_x),
    .unit_y    (unit_y),
    .unit_z    (unit_z),
    .zero_sum  (zero_sum)
  );

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the mesh vertex normal accumulator.
module testbench;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [9:0]         vid;
    logic signed [15:0] ux;
    logic signed [15:0] uy;
    logic signed [15:0] uz;
    logic               zs;
  } normal_t;

  typedef struct {
    logic [1:0]         op;
    logic [9:0]         a;
    logic [9:0]         b;
    logic [9:0]         c;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    bit                 typed;
    normal_t            want;
  } row_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [1:0]         opcode;
  logic [9:0]         index_a;
  logic [9:0]         index_b;
  logic [9:0]         index_c;
  logic signed [15:0] coord_x;
  logic signed [15:0] coord_y;
  logic signed [15:0] coord_z;
  logic               done;
  logic [9:0]         vertex_id;
  logic signed [15:0] unit_x;
  logic signed [15:0] unit_y;
  logic signed [15:0] unit_z;
  logic               zero_sum;

  // Predictor state: positions, saturating sums and which vertices hold a position.
  int     pos_x [mvna_pkg::MAX_VERTICES];
  int     pos_y [mvna_pkg::MAX_VERTICES];
  int     pos_z [mvna_pkg::MAX_VERTICES];
  longint acc_x [mvna_pkg::MAX_VERTICES];
  longint acc_y [mvna_pkg::MAX_VERTICES];
  longint acc_z [mvna_pkg::MAX_VERTICES];
  bit     placed [mvna_pkg::MAX_VERTICES];
  int     placed_list[$];

  normal_t pending_normals[$];
  row_t    directed_rows[$];
  int      mismatches;
  int      normals_seen;
  int      loads_sent, tris_sent, reads_sent;

  mesh_vertex_normal_accumulator dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .index_a(index_a), .index_b(index_b), .index_c(index_c),
    .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
    .done(done), .vertex_id(vertex_id), .unit_x(unit_x), .unit_y(unit_y),
    .unit_z(unit_z), .zero_sum(zero_sum)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("Timeout with %0d normals still outstanding.", pending_normals.size());
    $display("FAILED: results differ");
    $finish;
  end

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Scales a vector to unit length in Q1.14; returns 0 for a zero vector.
  function automatic bit unit_vector(input longint cx, input longint cy, input longint cz,
                                     output int ux, output int uy, output int uz);
    longint unsigned m[3];
    longint          cv[3];
    longint unsigned top, r, q;
    int              res[3];
    cv[0] = cx; cv[1] = cy; cv[2] = cz;
    for (int i = 0; i < 3; i++) begin
      m[i] = (cv[i] < 0) ? longint'(-cv[i]) : longint'(cv[i]);
      res[i] = 0;
    end
    ux = 0; uy = 0; uz = 0;
    if (m[0] == 0 && m[1] == 0 && m[2] == 0) return 1'b0;
    forever begin
      top = m[0];
      if (m[1] > top) top = m[1];
      if (m[2] > top) top = m[2];
      if (top < (64'd1 << 31)) break;
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
    end
    r = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
    if (r == 0) return 1'b0;
    for (int i = 0; i < 3; i++) begin
      q = (m[i] * 16384 + r / 2) / r;
      res[i] = (cv[i] < 0) ? -int'(q) : int'(q);
    end
    ux = res[0]; uy = res[1]; uz = res[2];
    return 1'b1;
  endfunction

  function automatic longint clamp_sum(input longint s, input int d);
    longint hi;
    longint t;
    hi = (64'sd1 <<< (mvna_pkg::SUM_WIDTH - 1)) - 1;
    t = s + d;
    if (t > hi) t = hi;
    if (t < -hi - 1) t = -hi - 1;
    return t;
  endfunction

  // Applies one accepted item to the predictor and returns its normal, if any.
  function automatic bit predict_normal(input row_t it, output normal_t n);
    longint e1[3], e2[3];
    longint crx, cry, crz;
    int     ux, uy, uz;
    int     v[3];
    bit     nz;
    n = '{vid: it.a, ux: 0, uy: 0, uz: 0, zs: 1'b1};
    case (it.op)
      mvna_pkg::OP_LOAD: begin
        pos_x[it.a] = it.x; pos_y[it.a] = it.y; pos_z[it.a] = it.z;
        acc_x[it.a] = 0; acc_y[it.a] = 0; acc_z[it.a] = 0;
        if (!placed[it.a]) placed_list.insert(placed_list.size(), int'(it.a));
        placed[it.a] = 1'b1;
        return 1'b0;
      end
      mvna_pkg::OP_TRI: begin
        e1[0] = pos_x[it.b] - pos_x[it.a]; e1[1] = pos_y[it.b] - pos_y[it.a];
        e1[2] = pos_z[it.b] - pos_z[it.a];
        e2[0] = pos_x[it.c] - pos_x[it.a]; e2[1] = pos_y[it.c] - pos_y[it.a];
        e2[2] = pos_z[it.c] - pos_z[it.a];
        crx = e1[1] * e2[2] - e1[2] * e2[1];
        cry = e1[2] * e2[0] - e1[0] * e2[2];
        crz = e1[0] * e2[1] - e1[1] * e2[0];
        if (unit_vector(crx, cry, crz, ux, uy, uz)) begin
          v[0] = it.a; v[1] = it.b; v[2] = it.c;
          for (int i = 0; i < 3; i++) begin
            acc_x[v[i]] = clamp_sum(acc_x[v[i]], ux);
            acc_y[v[i]] = clamp_sum(acc_y[v[i]], uy);
            acc_z[v[i]] = clamp_sum(acc_z[v[i]], uz);
          end
        end
        return 1'b0;
      end
      mvna_pkg::OP_READ: begin
        nz = unit_vector(acc_x[it.a], acc_y[it.a], acc_z[it.a], ux, uy, uz);
        n = '{vid: it.a, ux: 16'(ux), uy: 16'(uy), uz: 16'(uz), zs: !nz};
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Called just after a falling edge; returns just after the falling edge that follows acceptance.
  task automatic send_item(input row_t it);
    normal_t n;
    opcode = it.op; index_a = it.a; index_b = it.b; index_c = it.c;
    coord_x = it.x; coord_y = it.y; coord_z = it.z;
    start = 1'b1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    if (predict_normal(it, n))
      pending_normals.insert(pending_normals.size(), it.typed ? it.want : n);
    case (it.op)
      mvna_pkg::OP_LOAD: loads_sent++;
      mvna_pkg::OP_TRI:  tris_sent++;
      mvna_pkg::OP_READ: reads_sent++;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic pause_sender(input int cycles);
    start = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  function automatic row_t mk(input logic [1:0] op, input int a, input int b, input int c,
                              input int x, input int y, input int z);
    mk = '{op: op, a: 10'(a), b: 10'(b), c: 10'(c), x: 16'(x), y: 16'(y), z: 16'(z),
           typed: 1'b0, want: '{default: 0}};
  endfunction

  function automatic row_t mk_read(input int a, input bit typed, input int ux,
                                   input int uy, input int uz, input bit zs);
    mk_read = mk(mvna_pkg::OP_READ, a, 0, 0, 0, 0, 0);
    mk_read.typed = typed;
    mk_read.want = '{vid: 10'(a), ux: 16'(ux), uy: 16'(uy), uz: 16'(uz), zs: zs};
  endfunction

  function automatic void add_row(input row_t r);
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  function automatic logic signed [15:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'($urandom);
      default: return 16'($signed($urandom_range(0, 4095)) - 2048);
    endcase
  endfunction

  function automatic int rand_vertex();
    if ($urandom_range(0, 4) != 0) return $urandom_range(0, 15);
    return $urandom_range(0, mvna_pkg::MAX_VERTICES - 1);
  endfunction

  function automatic int rand_placed();
    return placed_list[$urandom_range(0, placed_list.size() - 1)];
  endfunction

  // Checks each strobed normal against the oldest expectation.
  always @(posedge clk) begin
    normal_t w;
    if (!rst && done) begin
      normals_seen++;
      if (pending_normals.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected normal for vertex %0d at %0t", vertex_id, $time);
      end else begin
        w = pending_normals.pop_front();
        if (vertex_id !== w.vid || unit_x !== w.ux || unit_y !== w.uy ||
            unit_z !== w.uz || zero_sum !== w.zs) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected v%0d (%0d,%0d,%0d) z%0d, got v%0d (%0d,%0d,%0d) z%0d",
                     w.vid, w.ux, w.uy, w.uz, w.zs,
                     vertex_id, unit_x, unit_y, unit_z, zero_sum);
        end
      end
    end
  end

  initial begin
    row_t it;
    int   pick;
    mismatches = 0; normals_seen = 0;
    loads_sent = 0; tris_sent = 0; reads_sent = 0;
    for (int i = 0; i < mvna_pkg::MAX_VERTICES; i++) begin
      pos_x[i] = 0; pos_y[i] = 0; pos_z[i] = 0;
      acc_x[i] = 0; acc_y[i] = 0; acc_z[i] = 0; placed[i] = 1'b0;
    end
    rst = 1'b1; start = 1'b0; opcode = mvna_pkg::OP_LOAD;
    index_a = '0; index_b = '0; index_c = '0;
    coord_x = '0; coord_y = '0; coord_z = '0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // Directed rows: reset state, unit axes, degenerate and extreme triangles.
    add_row(mk_read(0, 1, 0, 0, 0, 1));
    add_row(mk_read(1023, 1, 0, 0, 0, 1));
    add_row(mk(mvna_pkg::OP_LOAD, 0, 0, 0, 0, 0, 0));
    add_row(mk(mvna_pkg::OP_LOAD, 1, 0, 0, 256, 0, 0));
    add_row(mk(mvna_pkg::OP_LOAD, 2, 0, 0, 0, 256, 0));
    add_row(mk(mvna_pkg::OP_TRI, 0, 1, 2, 0, 0, 0));
    add_row(mk_read(0, 1, 0, 0, 16384, 0));
    add_row(mk(mvna_pkg::OP_TRI, 0, 0, 1, 0, 0, 0));
    add_row(mk(mvna_pkg::OP_TRI, 1, 1, 1, 0, 0, 0));
    add_row(mk_read(1, 1, 0, 0, 16384, 0));
    add_row(mk(mvna_pkg::OP_TRI, 0, 2, 1, 0, 0, 0));
    add_row(mk_read(2, 1, 0, 0, 0, 1));
    add_row(mk(mvna_pkg::OP_LOAD, 3, 0, 0, -32768, -32768, -32768));
    add_row(mk(mvna_pkg::OP_LOAD, 4, 0, 0, 32767, -32768, 32767));
    add_row(mk(mvna_pkg::OP_LOAD, 5, 0, 0, 32767, 32767, -32768));
    add_row(mk(mvna_pkg::OP_TRI, 3, 4, 5, 0, 0, 0));
    add_row(mk_read(3, 0, 0, 0, 0, 0));
    add_row(mk(mvna_pkg::OP_LOAD, 1023, 0, 0, 32767, 32767, 32767));
    add_row(mk(mvna_pkg::OP_TRI, 1023, 3, 1, 0, 0, 0));
    add_row(mk_read(1023, 0, 0, 0, 0, 0));
    add_row(mk(OP_UNUSED, 1023, 1023, 1023, -1, -1, -1));
    add_row(mk(mvna_pkg::OP_LOAD, 0, 0, 0, 5, 5, 5));
    add_row(mk_read(0, 1, 0, 0, 0, 1));
    add_row(mk_read(1, 0, 0, 0, 0, 0));
    foreach (directed_rows[i]) send_item(directed_rows[i]);

    // Random mix on a small hot set of vertices, with random sender gaps.
    for (int n = 0; n < 350; n++) begin
      if ($urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 11));
      if (n == 175) begin
        start = 1'b0;
        while (pending_normals.size() != 0) @(negedge clk);
      end
      pick = $urandom_range(0, 19);
      if (pick < 5) it = mk(mvna_pkg::OP_LOAD, rand_vertex(), $urandom_range(0, 1023),
                            $urandom_range(0, 1023), rand_coord(), rand_coord(), rand_coord());
      else if (pick < 13) begin
        it = mk(mvna_pkg::OP_TRI, rand_placed(), rand_placed(), rand_placed(),
                rand_coord(), rand_coord(), rand_coord());
        if ($urandom_range(0, 9) == 0) it.c = it.b;
      end
      else if (pick < 19) it = mk(mvna_pkg::OP_READ, rand_vertex(), $urandom_range(0, 1023),
                                  $urandom_range(0, 1023), rand_coord(), rand_coord(),
                                  rand_coord());
      else it = mk(OP_UNUSED, $urandom_range(0, 1023), $urandom_range(0, 1023),
                   $urandom_range(0, 1023), rand_coord(), rand_coord(), rand_coord());
      send_item(it);
    end

    // Back to back: one full-size triangle along +z repeated until its corner
    // sums saturate.
    send_item(mk(mvna_pkg::OP_LOAD, 40, 0, 0, -32768, -32768, 0));
    send_item(mk(mvna_pkg::OP_LOAD, 41, 0, 0, 32767, -32768, 0));
    send_item(mk(mvna_pkg::OP_LOAD, 42, 0, 0, -32768, 32767, 0));
    for (int n = 0; n < 540; n++) begin
      if (n % 60 == 0) send_item(mk_read(40 + n % 3, 0, 0, 0, 0, 0));
      else send_item(mk(mvna_pkg::OP_TRI, 40, 41, 42, 0, 0, 0));
    end
    for (int v = 40; v < 43; v++) send_item(mk_read(v, 0, 0, 0, 0, 0));
    start = 1'b0;

    while (pending_normals.size() != 0) @(negedge clk);
    repeat (150) @(negedge clk);
    $display("Covered %0d loads, %0d triangles and %0d reads; %0d normals checked.",
             loads_sent, tris_sent, reads_sent, normals_seen);
    $display("Saturated corner sums were read back, and %0d mismatches seen.", mismatches);
    if (mismatches == 0 && pending_normals.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
